[hdl/pti_pkg.sv]
// Shared types and constants for the piece table insert block.
// Holds entry layout, status codes and controller/datapath command structs.
// No dependencies.
`default_nettype none

package pti_pkg;

  // Default table depth
  localparam int MAX_PIECES_DEF = 256;

  // Field widths
  localparam int POS_W  = 32;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 32;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  // Stream widths (fields packed, padded to whole bytes)
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 80;

  // Item kinds
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } pti_status_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic             src;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } pti_entry_t;

  // RAM read address select
  typedef enum logic [1:0] {
    RS_INDEX,
    RS_ZERO,
    RS_WALK,
    RS_SHIFT
  } pti_rsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_in;
    pti_rsel_t rsel;
    logic      walk_init;
    logic      walk_step;
    logic      plan;
    logic      shift_step;
    logic      write_step;
    logic      append;
    logic      set_read_res;
    logic      push;
  } pti_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_end;
    logic walk_hit;
    logic full;
    logic shift_done;
    logic write_last;
    logic out_full;
  } pti_st_t;

endpackage

`default_nettype wire

[hdl/pti_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Used for the piece table storage. No dependencies.
`default_nettype none

module pti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/pti_ctrl.sv]
// Control state machine for the piece table insert block.
// Sequences read, walk, split, shift and write steps; depends on pti_pkg.
`default_nettype none

module pti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_mode,
  output logic              in_tready,
  output pti_pkg::pti_cmd_t cmd,
  input  pti_pkg::pti_st_t  st
);
  import pti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_WALK_START,
    S_WALK,
    S_PLAN,
    S_SHIFT,
    S_WRITE,
    S_APPEND,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = RS_ZERO;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (in_mode == MODE_READ) ? S_RD_ADDR : S_WALK_START;
        end
      end
      S_RD_ADDR: begin
        cmd.rsel  = RS_INDEX;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.set_read_res = 1'b1;
        state_nxt        = S_DONE;
      end
      S_WALK_START: begin
        cmd.rsel      = RS_ZERO;
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.rsel = RS_WALK;
        if (st.walk_end) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.walk_step = 1'b1;
          if (st.walk_hit) begin
            state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = st.full ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        cmd.rsel       = RS_SHIFT;
        cmd.shift_step = 1'b1;
        if (st.shift_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_step = 1'b1;
        if (st.write_last) begin
          state_nxt = S_DONE;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!st.out_full) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/pti_dp.sv]
// Datapath for the piece table insert block: table RAM, position walk,
// split pieces, shift pointers, count and output register. Uses pti_pkg, pti_ram.
`default_nettype none

module pti_dp #(
  parameter int MAX_PIECES = pti_pkg::MAX_PIECES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pti_pkg::pti_cmd_t          cmd,
  output pti_pkg::pti_st_t           st,
  input  logic [pti_pkg::POS_W-1:0]  insert_position,
  input  logic                       new_source,
  input  logic [pti_pkg::OFF_W-1:0]  new_offset,
  input  logic [pti_pkg::LEN_W-1:0]  new_length,
  input  logic [pti_pkg::IDX_W-1:0]  read_index,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [pti_pkg::STAT_W-1:0] status,
  output logic [pti_pkg::CNT_W-1:0]  entry_count,
  output logic                       entry_source,
  output logic [pti_pkg::OFF_W-1:0]  entry_offset,
  output logic [pti_pkg::LEN_W-1:0]  entry_length
);
  import pti_pkg::*;

  localparam int AW = $clog2(MAX_PIECES);
  localparam int CW = $clog2(MAX_PIECES + 1);
  localparam int EW = $bits(pti_entry_t);
  localparam int RW = (CW > IDX_W) ? CW : IDX_W;

  // latched item
  logic [POS_W-1:0] pos_r;
  pti_entry_t       new_e_r;
  logic [IDX_W-1:0] ridx_r;

  // table state and walk/split/shift registers
  logic [CW-1:0]    total_r;
  logic [CW-1:0]    chk_r;
  logic [POS_W-1:0] run_r;
  logic [CW-1:0]    hit_r;
  logic [LEN_W-1:0] inner_r;
  pti_entry_t       hit_e_r;
  logic [CW-1:0]    sh_rd_r;
  logic             sh_pend_r;
  logic [AW-1:0]    sh_wa_r;
  logic [1:0]       wcnt_r;

  // staged result and output register
  pti_status_t      res_stat_r;
  pti_entry_t       res_e_r;
  logic             out_valid_r;
  pti_status_t      out_stat_r;
  logic [CW-1:0]    out_cnt_r;
  pti_entry_t       out_e_r;

  // RAM port signals
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  pti_entry_t       ram_wdata;
  pti_entry_t       rd_e;

  logic [POS_W:0]   next_sum;
  logic             walk_hit;
  logic             has_left;
  logic             has_right;
  logic [1:0]       kminus1;
  logic [CW:0]      need;
  logic             full;
  logic             app_full;
  logic             shift_more;
  logic             write_last;
  logic             is_left;
  logic             is_new;
  pti_entry_t       piece;

  pti_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PIECES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = pti_entry_t'(ram_rdata);

  // walk compare: position falls inside or at the end of the current piece
  assign next_sum = {1'b0, run_r} + {1'b0, rd_e.len};
  assign walk_hit = {1'b0, pos_r} <= next_sum;

  // split plan: left part when inner offset nonzero, right part when below length
  assign has_left   = inner_r != '0;
  assign has_right  = inner_r < hit_e_r.len;
  assign kminus1    = {1'b0, has_left} + {1'b0, has_right};
  assign need       = {1'b0, total_r} + (CW + 1)'(kminus1);
  assign full       = need > (CW + 1)'(MAX_PIECES);
  assign app_full   = total_r == CW'(MAX_PIECES);
  assign shift_more = sh_rd_r > hit_r;
  assign write_last = wcnt_r == kminus1;

  // piece for the current write slot
  assign is_left = has_left && (wcnt_r == 2'd0);
  assign is_new  = wcnt_r == {1'b0, has_left};
  always_comb begin
    if (is_left) begin
      piece = '{src: hit_e_r.src, off: hit_e_r.off, len: inner_r};
    end else if (is_new) begin
      piece = new_e_r;
    end else begin
      piece = '{src: hit_e_r.src, off: hit_e_r.off + inner_r,
                len: hit_e_r.len - inner_r};
    end
  end

  // read address select
  always_comb begin
    case (cmd.rsel)
      RS_INDEX: ram_raddr = AW'(ridx_r);
      RS_ZERO:  ram_raddr = '0;
      RS_WALK:  ram_raddr = AW'(chk_r + CW'(1));
      RS_SHIFT: ram_raddr = AW'(sh_rd_r);
      default:  ram_raddr = '0;
    endcase
  end

  // write port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = piece;
    if (cmd.shift_step && sh_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = sh_wa_r;
      ram_wdata = rd_e;
    end else if (cmd.write_step) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(hit_r) + AW'(wcnt_r);
    end else if (cmd.append && !app_full) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(total_r);
      ram_wdata = new_e_r;
    end
  end

  // status to controller
  always_comb begin
    st            = '0;
    st.walk_end   = chk_r == total_r;
    st.walk_hit   = walk_hit;
    st.full       = full;
    st.shift_done = !shift_more && !sh_pend_r;
    st.write_last = write_last;
    st.out_full   = out_valid_r;
  end

  // item latch, walk, split and shift registers (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_r   <= insert_position;
      new_e_r <= '{src: new_source, off: new_offset, len: new_length};
      ridx_r  <= read_index;
    end
    if (cmd.walk_init) begin
      chk_r <= '0;
      run_r <= '0;
    end
    if (cmd.walk_step) begin
      if (walk_hit) begin
        hit_r   <= chk_r;
        inner_r <= pos_r - run_r;
        hit_e_r <= rd_e;
      end else begin
        run_r <= next_sum[POS_W-1:0];
        chk_r <= chk_r + CW'(1);
      end
    end
    if (cmd.plan) begin
      res_stat_r <= full ? ST_FULL : ST_OK;
      res_e_r    <= '0;
      sh_rd_r    <= (kminus1 != 2'd0) ? total_r - CW'(1) : hit_r;
      sh_pend_r  <= 1'b0;
      wcnt_r     <= 2'd0;
    end
    // shift later entries up, one read and one write per cycle
    if (cmd.shift_step) begin
      if (shift_more) begin
        sh_pend_r <= 1'b1;
        sh_wa_r   <= AW'(sh_rd_r) + AW'(kminus1);
        sh_rd_r   <= sh_rd_r - CW'(1);
      end else begin
        sh_pend_r <= 1'b0;
      end
    end
    if (cmd.write_step) begin
      wcnt_r <= wcnt_r + 2'd1;
    end
    if (cmd.append) begin
      res_e_r    <= '0;
      res_stat_r <= app_full ? ST_FULL : ST_OK;
    end
    if (cmd.set_read_res) begin
      if (RW'(ridx_r) < RW'(total_r)) begin
        res_stat_r <= ST_OK;
        res_e_r    <= rd_e;
      end else begin
        res_stat_r <= ST_BAD_INDEX;
        res_e_r    <= '0;
      end
    end
    if (cmd.push) begin
      out_stat_r <= res_stat_r;
      out_cnt_r  <= total_r;
      out_e_r    <= res_e_r;
    end
  end

  // piece count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write_step && write_last) begin
        total_r <= total_r + CW'(kminus1);
      end else if (cmd.append && !app_full) begin
        total_r <= total_r + CW'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign status       = out_stat_r;
  assign entry_count  = CNT_W'(out_cnt_r);
  assign entry_source = out_e_r.src;
  assign entry_offset = out_e_r.off;
  assign entry_length = out_e_r.len;

`ifndef NO_ASSERTIONS
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_PIECES))
    else $error("piece count above table depth");

  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.write_step || cmd.append) |=> $stable(total_r))
    else $error("piece count changed outside a write or append");

  a_shift_nocollide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && cmd.shift_step) |-> (ram_waddr != ram_raddr))
    else $error("shift writes the entry it is reading");

  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !out_valid_r)
    else $error("result pushed over a pending item");
`endif

endmodule

`default_nettype wire

[hdl/piece_table_insert_top.sv]
// Piece table insert block, top level: stream ports and field packing.
// Instantiates pti_ctrl and pti_dp; depends on pti_pkg.
//
// Usage:
//   Input channel (in_*): one item per command. in_tuser is the mode, 0 inserts
//   a piece at a logical position, 1 reads one table entry. Output channel
//   (out_*): exactly one result item per input item, in order.
//   A read addresses the RAM, takes the entry and stages the result.
//   An insert with a split walks N pieces before the hit, shifts S later
//   entries up (one per cycle through the RAM's single read and single write
//   port) and writes K = 1..3 pieces. An append past the end, or an insert
//   refused as full, walks the N pieces and then stages the result.
//   Walk and shift together cover at most the count.
//   One item is worked on at a time; in_tready is high only when the block is
//   idle. The result sits in an output register, so the next item is taken
//   while the previous result still waits for out_tready.
//   A stalled receiver holds the finished result; the block then waits with
//   the next result until the output register is free.
//   Reset (rst_n low, synchronous) empties the table (count zero) and drops
//   any pending result; no clearing pass is needed.
`default_nettype none

module piece_table_insert_top #(
  parameter int MAX_PIECES = pti_pkg::MAX_PIECES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: insert_position[31:0], new_source[32], new_offset[64:33],
  //           new_length[96:65], read_index[104:97], zero pad
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pti_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[0]
  input  logic                           in_tuser,
  // out_tdata: entry_count[8:0], entry_source[9], entry_offset[41:10],
  //            entry_length[73:42], zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pti_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [pti_pkg::STAT_W-1:0]     out_tuser
);
  import pti_pkg::*;

  pti_cmd_t          cmd;
  pti_st_t           st;
  logic [CNT_W-1:0]  entry_count;
  logic              entry_source;
  logic [OFF_W-1:0]  entry_offset;
  logic [LEN_W-1:0]  entry_length;

  pti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  pti_dp #(
    .MAX_PIECES (MAX_PIECES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .insert_position (in_tdata[31:0]),
    .new_source      (in_tdata[32]),
    .new_offset      (in_tdata[64:33]),
    .new_length      (in_tdata[96:65]),
    .read_index      (in_tdata[104:97]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .status          (out_tuser),
    .entry_count     (entry_count),
    .entry_source    (entry_source),
    .entry_offset    (entry_offset),
    .entry_length    (entry_length)
  );

  // result packing, lowest field first
  assign out_tdata = {6'd0, entry_length, entry_offset, entry_source, entry_count};

endmodule

`default_nettype wire

[verif/piece_table_insert_top_tb.sv]
// Self-checking testbench for piece_table_insert_top: mixes edits and entry reads
// against a piece-table predictor. It randomizes stalls on both streams.
// Depends on pti_pkg and the piece_table_insert_top RTL.
module piece_table_insert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pti_pkg::*;

  localparam int DEPTH      = MAX_PIECES_DEF;
  localparam int RAND_ITEMS = 1134;
  localparam int LATE_ITEMS = 900;   // huge piece lengths only after this point
  localparam int STALL_AT   = 300;   // reply count that triggers the long hold-off
  localparam int STALL_LEN  = 1500;
  localparam int DRAIN_CYC  = 600;

  // One edit or read command as driven on the input stream
  typedef struct packed {
    logic        mode;
    logic [31:0] pos;
    logic        src;
    logic [31:0] off;
    logic [31:0] len;
    logic [7:0]  idx;
  } edit_cmd_t;

  // One reply as expected on the output stream
  typedef struct packed {
    pti_status_t status;
    logic [8:0]  count;
    logic        src;
    logic [31:0] off;
    logic [31:0] len;
  } piece_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  // Shadow of the piece table
  logic        tbl_src [DEPTH];
  logic [31:0] tbl_off [DEPTH];
  logic [31:0] tbl_len [DEPTH];
  int          tbl_count = 0;

  edit_cmd_t    cmd_q[$];
  piece_reply_t reply_q[$];
  edit_cmd_t    cur_cmd;

  int pushed_n = 0;
  int accepted_n = 0;
  int results_seen = 0;
  int mismatches = 0;
  int tx_gap = 0, tx_calm = 0;
  int rx_gap = 0, rx_calm = 0;
  int hold_left = 0;
  bit hold_armed = 1'b1;

  piece_table_insert_top #(.MAX_PIECES(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before the next item; runs of zero give back-to-back stretches
  function automatic int idle_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Sum of piece lengths below entry 'upto'
  function automatic logic [63:0] doc_bytes(input int upto);
    logic [63:0] sum;
    int i;
    sum = '0;
    for (i = 0; i < upto; i++) sum += tbl_len[i];
    return sum;
  endfunction

  // Apply one command to the shadow table and return the reply it produces
  function automatic piece_reply_t table_apply(input edit_cmd_t c);
    piece_reply_t r;
    logic [63:0]  run, nxt;
    logic [31:0]  inner, ho, hl;
    logic         hs, found;
    logic         ps [3];
    logic [31:0]  po [3], pl [3];
    int           n, hit, k, i;
    r = '0;
    r.status = ST_OK;
    n = tbl_count;
    if (c.mode == MODE_READ) begin
      if (int'(c.idx) < n) begin
        r.src = tbl_src[c.idx];
        r.off = tbl_off[c.idx];
        r.len = tbl_len[c.idx];
      end else begin
        r.status = ST_BAD_INDEX;
      end
    end else begin
      // walk running lengths; a position at a piece's end belongs to it
      run = '0;
      hit = n;
      inner = '0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!found) begin
          nxt = run + tbl_len[i];
          if ({32'd0, c.pos} <= nxt) begin
            hit = i;
            inner = c.pos - run[31:0];
            found = 1'b1;
          end
          run = nxt;
        end
      end
      if (!found) begin
        // past the end: append
        if (n + 1 > DEPTH) r.status = ST_FULL;
        else begin
          tbl_src[n] = c.src;
          tbl_off[n] = c.off;
          tbl_len[n] = c.len;
          tbl_count = n + 1;
        end
      end else begin
        hs = tbl_src[hit];
        ho = tbl_off[hit];
        hl = tbl_len[hit];
        k = 0;
        if (inner != 0) begin
          ps[k] = hs; po[k] = ho; pl[k] = inner; k++;
        end
        ps[k] = c.src; po[k] = c.off; pl[k] = c.len; k++;
        if (inner < hl) begin
          ps[k] = hs; po[k] = ho + inner; pl[k] = hl - inner; k++;
        end
        if (n + k - 1 > DEPTH) r.status = ST_FULL;
        else begin
          // open a gap of k-1 entries above the hit piece
          for (i = n; i > hit + 1; i--) begin
            tbl_src[i - 1 + k - 1] = tbl_src[i - 1];
            tbl_off[i - 1 + k - 1] = tbl_off[i - 1];
            tbl_len[i - 1 + k - 1] = tbl_len[i - 1];
          end
          for (i = 0; i < k; i++) begin
            tbl_src[hit + i] = ps[i];
            tbl_off[hit + i] = po[i];
            tbl_len[hit + i] = pl[i];
          end
          tbl_count = n + k - 1;
        end
      end
    end
    r.count = tbl_count[8:0];
    return r;
  endfunction

  task automatic push_cmd(input logic mode, input logic [31:0] pos, input logic src,
                          input logic [31:0] off, input logic [31:0] len,
                          input logic [7:0] idx);
    edit_cmd_t c;
    c.mode = mode;
    c.pos  = pos;
    c.src  = src;
    c.off  = off;
    c.len  = len;
    c.idx  = idx;
    cmd_q.push_back(c);
    pushed_n++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // Input driver: one item in flight, predicted at the accepting edge
  always @(posedge clk) begin : tx_side
    logic nv;
    nv = in_tvalid;
    if (!rst_n) begin
      nv = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        reply_q.push_back(table_apply(cur_cmd));
        accepted_n++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap != 0) tx_gap--;
        else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          nv = 1'b1;
          in_tdata <= {7'd0, cur_cmd.idx, cur_cmd.len, cur_cmd.off, cur_cmd.src,
                       cur_cmd.pos};
          in_tuser <= cur_cmd.mode;
          tx_gap = idle_draw(tx_calm);
        end
      end
    end
    in_tvalid <= nv;
  end

  // Long receiver hold-off so the output register fills and input stalls
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen >= STALL_AT) begin
      hold_left <= STALL_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: compare each reply with the oldest prediction
  always @(posedge clk) begin : rx_side
    piece_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply, expected none, actual status %0h data %0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("entry_count", 32'(want.count), 32'(out_tdata[8:0]));
          check_field("entry_source", 32'(want.src), 32'(out_tdata[9]));
          check_field("entry_offset", want.off, out_tdata[41:10]);
          check_field("entry_length", want.len, out_tdata[73:42]);
        end
        results_seen <= results_seen + 1;
        rx_gap = idle_draw(rx_calm);
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      out_tready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // Stimulus and end of run
  initial begin : stim
    int          n, sel, cnt;
    logic [63:0] doclen, rnd, e;
    logic [31:0] pos, len;
    logic [7:0]  idx;

    // reads on an empty table
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd0);
    push_cmd(MODE_READ,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    // first piece goes in as an append
    push_cmd(MODE_INSERT, 32'd0, 1'b0, 32'd0, 32'd100, 8'd0);
    // position at the piece's end: left part only, zero-length new piece
    push_cmd(MODE_INSERT, 32'd100, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'd0);
    // position at the start: new piece then right part
    push_cmd(MODE_INSERT, 32'd0, 1'b1, 32'd5, 32'd10, 8'd0);
    // split in the middle: three pieces
    push_cmd(MODE_INSERT, 32'd50, 1'b0, 32'h1234, 32'd7, 8'd0);
    // far past the end: append near the top of the offset range
    push_cmd(MODE_INSERT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF0, 32'h40, 8'd0);
    // split that piece so the right part's offset wraps
    push_cmd(MODE_INSERT, 32'd149, 1'b1, 32'd0, 32'h100, 8'd0);
    // zero-length piece at the front, then replaced by an insert at its start
    push_cmd(MODE_INSERT, 32'd0, 1'b1, 32'hAAAA_AAAA, 32'd0, 8'd0);
    push_cmd(MODE_INSERT, 32'd0, 1'b0, 32'h5555_5555, 32'd3, 8'd0);
    // reads: first, last, one past the count, top index
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd0);
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd8);
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd9);
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd255);
    push_cmd(MODE_INSERT, 32'd1, 1'b1, 32'd0, 32'd1, 8'd0);
    push_cmd(MODE_READ,   32'd0, 1'b0, 32'd0, 32'd0, 8'd5);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // random mix, shaped from the current table contents
    for (n = 0; n < RAND_ITEMS; n++) begin
      while (cmd_q.size() >= 2) @(posedge clk);
      cnt = tbl_count;
      doclen = doc_bytes(cnt);
      if ($urandom_range(0, 99) < 35) begin
        sel = $urandom_range(0, 9);
        if (cnt != 0 && sel < 7) idx = 8'($urandom_range(0, cnt - 1));
        else if (sel < 9) idx = 8'($urandom);
        else idx = (cnt > 255) ? 8'hFF : cnt[7:0];
        push_cmd(MODE_READ, $urandom, 1'($urandom), $urandom, $urandom, idx);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          rnd = {$urandom, $urandom};
          pos = (doclen > 64'hFFFF_FFFF) ? $urandom : 32'(rnd % (doclen + 1));
        end else if (sel < 65 && cnt != 0) begin
          // exactly on a piece boundary
          e = doc_bytes($urandom_range(1, cnt));
          pos = (e > 64'hFFFF_FFFF) ? $urandom : e[31:0];
        end else if (sel < 75) begin
          pos = '0;
        end else if (sel < 85) begin
          pos = (doclen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : doclen[31:0];
        end else begin
          pos = $urandom;
        end
        sel = $urandom_range(0, 99);
        if (sel < 15) len = '0;
        else if (n < LATE_ITEMS || sel < 92) len = $urandom_range(1, 64);
        else if (sel < 97) len = $urandom;
        else len = '1;
        push_cmd(MODE_INSERT, pos, 1'($urandom), $urandom, len, 8'($urandom));
      end
    end

    // drain
    while (accepted_n != pushed_n) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hdl/pti_pkg.sv
hdl/pti_ram.sv
hdl/pti_ctrl.sv
hdl/pti_dp.sv
hdl/piece_table_insert_top.sv
verif/piece_table_insert_top_tb.sv
